>>> hw/rtl/pssk_pkg.sv
// ----------------------------------------------------------------------------
// pssk_pkg
// Shared types and constants for the PS/2 set-1 scancode key tracker.
// ----------------------------------------------------------------------------
package pssk_pkg;

   localparam int SCAN_W   = 8;
   localparam int CODE_W   = 7;
   localparam int MOD_W    = 8;
   localparam int SPEC_W   = 6;

   localparam int REQ_TDATA_W = 8;
   localparam int REQ_TUSER_W = 1;
   localparam int RSP_TDATA_W = 32;

   // request opcodes (carried in tuser)
   localparam logic OP_SCAN = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [SCAN_W-1:0] PREFIX_BYTE   = 8'hE0;
   localparam logic [SCAN_W-1:0] OVERFLOW_CODE = 8'hFF;
   localparam int                RELEASE_BIT   = 7;

   // unprefixed modifier codes
   localparam logic [CODE_W-1:0] KEY_LCTRL  = 7'h1D;
   localparam logic [CODE_W-1:0] KEY_LSHIFT = 7'h2A;
   localparam logic [CODE_W-1:0] KEY_RSHIFT = 7'h36;
   localparam logic [CODE_W-1:0] KEY_LALT   = 7'h38;
   // prefixed codes
   localparam logic [CODE_W-1:0] KEY_LSUPER = 7'h5B;
   localparam logic [CODE_W-1:0] KEY_RSUPER = 7'h5C;
   localparam logic [CODE_W-1:0] KEY_RCTRL  = 7'h1D;
   localparam logic [CODE_W-1:0] KEY_RALT   = 7'h38;
   localparam logic [CODE_W-1:0] KEY_UP     = 7'h48;
   localparam logic [CODE_W-1:0] KEY_RIGHT  = 7'h4D;
   localparam logic [CODE_W-1:0] KEY_DOWN   = 7'h50;
   localparam logic [CODE_W-1:0] KEY_LEFT   = 7'h4B;
   localparam logic [CODE_W-1:0] KEY_PGUP   = 7'h49;
   localparam logic [CODE_W-1:0] KEY_PGDN   = 7'h51;

   typedef enum logic [1:0] {
      KIND_KEY,
      KIND_PREFIX,
      KIND_POP
   } kind_type;

   // classified beat, front -> queue -> back
   typedef struct packed {
      kind_type              kind;
      logic [CODE_W-1:0]     code;
      logic                  down;
      logic [MOD_W-1:0]      mod_mask;
      logic [SPEC_W-1:0]     spec_mask;
      logic                  prefix;     // prefix pending after this beat
   } action_type;

   // result fields held in the back end's output register
   typedef struct packed {
      logic [MOD_W-1:0]      modifier_bits;
      logic [SPEC_W-1:0]     special_bits;
      logic                  overflow_flag;
      logic                  prefix_pending;
      logic                  read_valid;
   } result_type;

endpackage

>>> hw/rtl/pssk_ram.sv
// ----------------------------------------------------------------------------
// pssk_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pssk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [AW-1:0]            rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hw/rtl/pssk_front.sv
// ----------------------------------------------------------------------------
// pssk_front
// Accepts request beats, tracks the E0 prefix and classifies each beat.
// ----------------------------------------------------------------------------
module pssk_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_opcode,
   input  logic [pssk_pkg::SCAN_W-1:0]   req_scan_byte,
   input  logic                          act_ready,
   output logic                          act_valid,
   output pssk_pkg::action_type          act
);
   logic extended_ff;
   logic extended_in;
   logic [pssk_pkg::CODE_W-1:0] code;

   assign code      = req_scan_byte[pssk_pkg::CODE_W-1:0];
   assign act_valid = req_valid;

   always_comb begin
      act           = '0;
      act.kind      = pssk_pkg::KIND_KEY;
      act.code      = code;
      act.down      = ~req_scan_byte[pssk_pkg::RELEASE_BIT];
      act.prefix    = 1'b0;
      if (req_opcode == pssk_pkg::OP_POP) begin
         act.kind   = pssk_pkg::KIND_POP;
         act.prefix = extended_ff;
      end else if (!extended_ff && req_scan_byte == pssk_pkg::PREFIX_BYTE) begin
         act.kind   = pssk_pkg::KIND_PREFIX;
         act.prefix = 1'b1;
      end else if (!extended_ff) begin
         unique case (code)
            pssk_pkg::KEY_LCTRL:  act.mod_mask = 8'h01;
            pssk_pkg::KEY_LSHIFT: act.mod_mask = 8'h02;
            pssk_pkg::KEY_RSHIFT: act.mod_mask = 8'h04;
            pssk_pkg::KEY_LALT:   act.mod_mask = 8'h08;
            default:              act.mod_mask = '0;
         endcase
      end else begin
         // second byte of a prefixed pair; E0 E0 lands here as release of 0x60
         unique case (code)
            pssk_pkg::KEY_LSUPER: act.mod_mask  = 8'h10;
            pssk_pkg::KEY_RSUPER: act.mod_mask  = 8'h20;
            pssk_pkg::KEY_RCTRL:  act.mod_mask  = 8'h40;
            pssk_pkg::KEY_RALT:   act.mod_mask  = 8'h80;
            pssk_pkg::KEY_UP:     act.spec_mask = 6'h01;
            pssk_pkg::KEY_RIGHT:  act.spec_mask = 6'h02;
            pssk_pkg::KEY_DOWN:   act.spec_mask = 6'h04;
            pssk_pkg::KEY_LEFT:   act.spec_mask = 6'h08;
            pssk_pkg::KEY_PGUP:   act.spec_mask = 6'h10;
            pssk_pkg::KEY_PGDN:   act.spec_mask = 6'h20;
            default:              act.mod_mask  = '0;
         endcase
      end
   end

   assign extended_in = (req_valid && act_ready) ? act.prefix : extended_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         extended_ff <= 1'b0;
      end else begin
         extended_ff <= extended_in;
      end
   end
endmodule

>>> hw/rtl/pssk_queue.sv
// ----------------------------------------------------------------------------
// pssk_queue
// Two-entry FIFO of classified beats between front and back.
// ----------------------------------------------------------------------------
module pssk_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  pssk_pkg::action_type  in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output pssk_pkg::action_type  out_data
);
   localparam int QUEUE_DEPTH = 2;

   pssk_pkg::action_type entries_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'(QUEUE_DEPTH));
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entries_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= in_data;
      end
   end
endmodule

>>> hw/rtl/pssk_back.sv
// ----------------------------------------------------------------------------
// pssk_back
// Applies classified beats: key map, modifier/special bits, code ring.
// ----------------------------------------------------------------------------
module pssk_back #(
   parameter int RING_DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          act_valid,
   output logic                          act_ready,
   input  pssk_pkg::action_type          act,
   input  logic                          res_ready,
   output logic                          res_valid,
   output pssk_pkg::result_type          res,
   output logic [pssk_pkg::SCAN_W-1:0]   res_read_code
);
   localparam int RING_AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam logic [RING_AW-1:0] RING_LAST = RING_AW'(RING_DEPTH - 1);

   function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] pos);
      ring_next = (pos == RING_LAST) ? '0 : pos + 1'b1;
   endfunction

   logic                          res_valid_ff, res_valid_in;
   pssk_pkg::result_type          res_ff, res_in;
   logic [RING_AW-1:0]            head_ff, head_in;
   logic [RING_AW-1:0]            tail_ff, tail_in;
   logic [pssk_pkg::MOD_W-1:0]    mod_ff, mod_in;
   logic [pssk_pkg::SPEC_W-1:0]   spec_ff, spec_in;
   logic [127:0]                  pressed_ff, pressed_in;
   logic [RING_AW-1:0]            head_next, tail_next;
   logic                          fire, full;
   logic                          wr_en, rd_en;
   logic [RING_AW-1:0]            wr_addr, rd_addr;
   logic [pssk_pkg::SCAN_W-1:0]   wr_data, rd_data;

   assign act_ready = !res_valid_ff || res_ready;
   assign fire      = act_valid && act_ready;
   assign head_next = ring_next(head_ff);
   assign tail_next = ring_next(tail_ff);
   assign full      = (tail_next == head_ff);

   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      mod_in     = mod_ff;
      spec_in    = spec_ff;
      pressed_in = pressed_ff;
      wr_en      = 1'b0;
      wr_addr    = tail_next;
      wr_data    = {1'b0, act.code};
      rd_en      = 1'b0;
      rd_addr    = head_next;
      res_in     = '0;
      if (fire) begin
         case (act.kind)
            pssk_pkg::KIND_KEY: begin
               pressed_in[act.code] = act.down;
               mod_in  = act.down ? (mod_ff | act.mod_mask) : (mod_ff & ~act.mod_mask);
               spec_in = act.down ? (spec_ff | act.spec_mask)
                                  : (spec_ff & ~act.spec_mask);
               wr_en   = 1'b1;
               if (full) begin
                  // ring full: newest entry is overwritten with the marker
                  wr_addr = tail_ff;
                  wr_data = pssk_pkg::OVERFLOW_CODE;
               end else begin
                  tail_in = tail_next;
               end
               res_in.overflow_flag = full;
            end
            pssk_pkg::KIND_POP: begin
               if (head_ff != tail_ff) begin
                  rd_en             = 1'b1;
                  head_in           = head_next;
                  res_in.read_valid = 1'b1;
               end
            end
            default: begin
            end
         endcase
         res_in.modifier_bits  = mod_in;
         res_in.special_bits   = spec_in;
         res_in.prefix_pending = act.prefix;
      end
   end

   assign res_valid_in = fire ? 1'b1 : (res_ready ? 1'b0 : res_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         mod_ff       <= '0;
         spec_ff      <= '0;
         pressed_ff   <= '0;
      end else begin
         res_valid_ff <= res_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         mod_ff       <= mod_in;
         spec_ff      <= spec_in;
         pressed_ff   <= pressed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         res_ff <= res_in;
      end
   end

   pssk_ram #(
      .WIDTH (pssk_pkg::SCAN_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign res_valid     = res_valid_ff;
   assign res           = res_ff;
   // read data register holds while the result waits, since rd_en needs fire
   assign res_read_code = res_ff.read_valid ? rd_data : '0;
endmodule

>>> hw/rtl/ps2_scancode_key_tracker.sv
// ----------------------------------------------------------------------------
// ps2_scancode_key_tracker
// PS/2 scancode set 1 key tracker with a buffered code ring.
// ----------------------------------------------------------------------------
// Each request beat either delivers a raw keyboard byte (tuser = 0) or pops
// one buffered key code (tuser = 1); every beat yields exactly one response
// beat carrying the modifier and arrow/page bits as they stand after that
// beat, the overflow flag, whether an E0 prefix is pending, and the popped
// code with its valid bit. While rsp_tready is not held low, the block
// sustains one beat per clock cycle in both directions: the front end
// classifies a byte in the cycle it is taken, a two-entry queue decouples
// it from the back end, and the back end does at most one ring push or pop
// per cycle into its output register. An accepted request beat is written
// into the queue, and its response is registered in the back end's output
// register when the beat leaves the queue. The ring of RING_DEPTH entries
// holds RING_DEPTH-1 codes; it sits in a RAM with registered read and
// needs no clearing after reset, so the block takes beats from the first
// cycle after reset is released. A byte that finds the ring full overwrites
// the newest entry with 0xFF and raises overflow_flag.
// ----------------------------------------------------------------------------
module ps2_scancode_key_tracker #(
   parameter int RING_DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pssk_pkg::REQ_TDATA_W-1:0]  req_tdata,  // [7:0] scan_byte
   input  logic [pssk_pkg::REQ_TUSER_W-1:0]  req_tuser,  // [0] opcode
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pssk_pkg::RSP_TDATA_W-1:0]  rsp_tdata   // [7:0] modifier_bits,
                                                         // [13:8] special_bits,
                                                         // [14] overflow_flag,
                                                         // [15] prefix_pending,
                                                         // [23:16] read_code,
                                                         // [24] read_valid,
                                                         // [31:25] zero
);
   pssk_pkg::action_type           front_act, queue_act;
   logic                           front_valid, front_ready;
   logic                           queue_valid, back_ready;
   pssk_pkg::result_type           res;
   logic [pssk_pkg::SCAN_W-1:0]    res_read_code;

   // front end: prefix tracking and key classification
   pssk_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_opcode    (req_tuser[0]),
      .req_scan_byte (req_tdata[pssk_pkg::SCAN_W-1:0]),
      .act_ready     (front_ready),
      .act_valid     (front_valid),
      .act           (front_act)
   );

   assign req_tready = front_ready;

   // decoupling queue
   pssk_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_act),
      .out_valid (queue_valid),
      .out_ready (back_ready),
      .out_data  (queue_act)
   );

   // back end: state update, ring, output register
   pssk_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .act_valid     (queue_valid),
      .act_ready     (back_ready),
      .act           (queue_act),
      .res_ready     (rsp_tready),
      .res_valid     (rsp_tvalid),
      .res           (res),
      .res_read_code (res_read_code)
   );

   assign rsp_tdata = {7'd0, res.read_valid, res_read_code, res.prefix_pending,
                       res.overflow_flag, res.special_bits, res.modifier_bits};
endmodule

>>> hw/rtl/pssk_checker.sv
// ----------------------------------------------------------------------------
// pssk_checker
// Port-level assertions for the key tracker, bound to the top level.
// ----------------------------------------------------------------------------
module pssk_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tready,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata
);
   // no response beat is pending right after reset, and requests are taken
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid && req_tready)
      else $error("response valid or request blocked after reset");

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed under stall");

   // read_code is zero unless a pop succeeded
   a_code_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[24] |-> rsp_tdata[23:16] == 8'd0)
      else $error("read_code nonzero without read_valid");

   // a beat never shows both outcomes, overflow (push) and read_valid (pop)
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[14] && rsp_tdata[24]))
      else $error("overflow and read_valid together");
endmodule

bind ps2_scancode_key_tracker pssk_checker u_pssk_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
